/* rtl/bia_pkg.sv */
// Shared types, widths and codes for the bitmap inode and block allocator.
`default_nettype none

package bia_pkg;

    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;
    localparam int LIMIT_W         = 11;
    localparam int BPF_W           = 7;
    localparam int BLK_W           = 12;
    localparam int INO_W           = 10;
    localparam int CMD_W           = 2;
    localparam int ST_W            = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int REG_SEL_BIT     = 2;
    localparam int INODE_COUNT_DEF = 1024;
    localparam int BLOCK_COUNT_DEF = 4096;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd1024;
    localparam logic [BPF_W-1:0]   BPF_RST   = 7'd4;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_INODE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_RSVD     = 2'd3;

    localparam logic REG_INODE_LIMIT     = 1'b0;
    localparam logic REG_BLOCKS_PER_FILE = 1'b1;

    typedef struct packed {
        logic            latch;
        logic            clr_step;
        logic            scan_start;
        logic            scan_step;
        logic            mul;
        logic            ino_write;
        logic            blk_write;
        logic            finish;
        logic [ST_W-1:0] fin_status;
    } dp_cmd_t;

    typedef struct packed {
        logic             clr_done;
        logic             span_zero;
        logic             hit;
        logic             miss;
        logic             base_oob;
        logic             blk_oob;
        logic [CMD_W-1:0] cmd;
        logic             is_dir;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/bitmap_inode_block_allocator.sv */
// Top level of the bitmap inode and data-block allocator with its register port.
//
// Commands enter on start/command/is_directory/block_index and are taken when start
// is high and busy is low; busy stays high until the transaction has finished.
// Each command gives exactly one result on status/inode_number, shown for one
// cycle while done is high. The receiver cannot stall; results are never held.
// Allocate scans the inode bitmap one 32-bit memory word per cycle through a
// single read port, up to 32 words at the defaults; for a file inode the found
// bit is then set by writing its word back; a fruitless scan answers no inode.
// A directory adds a multiply, a range check and a read-modify-write of the
// block bitmap, or answers after the range check when its base block is out of
// range. A zero limit answers from dispatch without a scan. Mark and free do a
// read-modify-write of the block bitmap; an out-of-range block answers from
// dispatch. busy drops with done, so the next command can be taken in the done
// cycle; only one command is in flight. After reset both bitmaps are cleared
// one word per cycle, max(INODE_COUNT/32, BLOCK_COUNT/32) words (128 at the
// defaults); busy is high during that pass. The register port takes writes at
// any time; write it only while no command is in flight.
`default_nettype none

module bitmap_inode_block_allocator #(
    parameter int INODE_COUNT = bia_pkg::INODE_COUNT_DEF,
    parameter int BLOCK_COUNT = bia_pkg::BLOCK_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bia_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bia_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bia_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          start,
    input  wire logic [bia_pkg::CMD_W-1:0]     command,
    input  wire logic                          is_directory,
    input  wire logic [bia_pkg::BLK_W-1:0]     block_index,
    output logic                               busy,
    output logic                               done,
    output logic      [bia_pkg::ST_W-1:0]      status,
    output logic      [bia_pkg::INO_W-1:0]     inode_number
);

    logic [bia_pkg::LIMIT_W-1:0] limit_reg;
    logic [bia_pkg::BPF_W-1:0]   bpf_reg;
    logic                        cfg_wr;
    bia_pkg::dp_cmd_t            dp_cmd;
    bia_pkg::dp_stat_t           dp_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= bia_pkg::LIMIT_RST;
            bpf_reg   <= bia_pkg::BPF_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[bia_pkg::REG_SEL_BIT])
                bia_pkg::REG_INODE_LIMIT:     limit_reg <= pwdata[bia_pkg::LIMIT_W-1:0];
                bia_pkg::REG_BLOCKS_PER_FILE: bpf_reg   <= pwdata[bia_pkg::BPF_W-1:0];
                default:                      limit_reg <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[bia_pkg::REG_SEL_BIT])
            bia_pkg::REG_INODE_LIMIT:     prdata = bia_pkg::PDATA_W'(limit_reg);
            bia_pkg::REG_BLOCKS_PER_FILE: prdata = bia_pkg::PDATA_W'(bpf_reg);
            default:                      prdata = '0;
        endcase
    end

    bia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (dp_cmd),
        .stat  (dp_stat)
    );

    bia_dp #(
        .INODE_COUNT (INODE_COUNT),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .is_directory    (is_directory),
        .block_index     (block_index),
        .inode_limit     (limit_reg),
        .blocks_per_file (bpf_reg),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .done            (done),
        .status          (status),
        .inode_number    (inode_number)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != bia_pkg::ST_RSVD)
        else $error("reserved status code on result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != bia_pkg::ST_OK |-> inode_number == '0)
        else $error("failed transaction returned a nonzero inode number");

endmodule

`default_nettype wire

/* rtl/bia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bia_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/bia_ctrl.sv */
// Command sequencer of the allocator: clearing pass, dispatch, scan and commit steps.
`default_nettype none

module bia_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output bia_pkg::dp_cmd_t        cmd,
    input  wire bia_pkg::dp_stat_t  stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_INO,
        S_MUL,
        S_COMMIT,
        S_BRD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    bia_pkg::CMD_ALLOC:
                    begin
                        if (stat.span_zero)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = bia_pkg::ST_NO_INODE;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    bia_pkg::CMD_MARK, bia_pkg::CMD_FREE:
                    begin
                        if (stat.blk_oob)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = bia_pkg::ST_RANGE;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_BRD;
                        end
                    end
                    default:
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = bia_pkg::ST_OK;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    if (stat.is_dir)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_INO;
                    end
                end
                else if (stat.miss)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = bia_pkg::ST_NO_INODE;
                    state_next     = S_IDLE;
                end
            end
            S_INO:
            begin
                cmd.ino_write  = 1'b1;
                cmd.finish     = 1'b1;
                cmd.fin_status = bia_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.base_oob)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = bia_pkg::ST_RANGE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                cmd.blk_write  = 1'b1;
                cmd.ino_write  = (stat.cmd == bia_pkg::CMD_ALLOC);
                cmd.finish     = 1'b1;
                cmd.fin_status = bia_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* rtl/bia_dp.sv */
// Datapath of the allocator: bitmap memories, word scan, base multiply and result registers.
`default_nettype none

module bia_dp #(
    parameter int INODE_COUNT = bia_pkg::INODE_COUNT_DEF,
    parameter int BLOCK_COUNT = bia_pkg::BLOCK_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [bia_pkg::CMD_W-1:0]    command,
    input  wire logic                         is_directory,
    input  wire logic [bia_pkg::BLK_W-1:0]    block_index,
    input  wire logic [bia_pkg::LIMIT_W-1:0]  inode_limit,
    input  wire logic [bia_pkg::BPF_W-1:0]    blocks_per_file,
    input  wire bia_pkg::dp_cmd_t             cmd,
    output bia_pkg::dp_stat_t                 stat,
    output logic                              done,
    output logic      [bia_pkg::ST_W-1:0]     status,
    output logic      [bia_pkg::INO_W-1:0]    inode_number
);

    localparam int WW     = bia_pkg::WORD_W;
    localparam int BWD    = bia_pkg::BIT_W;
    localparam int LW     = bia_pkg::LIMIT_W;
    localparam int IOW    = bia_pkg::INO_W;
    localparam int IW     = (INODE_COUNT + WW - 1) / WW;
    localparam int IWA    = (IW > 1) ? $clog2(IW) : 1;
    localparam int IDX_W  = IWA + BWD;
    localparam int BW     = (BLOCK_COUNT + WW - 1) / WW;
    localparam int BWA    = (BW > 1) ? $clog2(BW) : 1;
    localparam int CLR_N  = (IW > BW) ? IW : BW;
    localparam int CLW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int PROD_W = IDX_W + bia_pkg::BPF_W;

    logic [bia_pkg::CMD_W-1:0] cmd_reg;
    logic                      dir_reg;
    logic [bia_pkg::BLK_W-1:0] blk_reg;
    logic [CLW-1:0]            clr_reg;
    logic [IWA-1:0]            scan_reg;
    logic                      issued_reg;
    logic                      rdv_reg;
    logic [IWA-1:0]            chk_reg;
    logic [IWA-1:0]            widx_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [WW-1:0]             word_reg;
    logic [PROD_W-1:0]         base_reg;
    logic                      done_reg;
    logic [bia_pkg::ST_W-1:0]  status_reg;
    logic [IOW-1:0]            inode_reg;

    logic [LW-1:0]     span;
    logic [LW-1:0]     span_m1;
    logic [LW-BWD-1:0] last_word;
    logic [LW-BWD-1:0] full_words;
    logic [WW-1:0]     tail_mask;
    logic [WW-1:0]     valid_mask;
    logic [WW-1:0]     free_bits;
    logic              any_free;
    logic [BWD-1:0]    pos;
    logic              scan_last;
    logic              chk_last;
    logic              clr_in_ino;
    logic              clr_in_blk;

    logic [WW-1:0]  ino_rdata;
    logic           ino_we;
    logic [IWA-1:0] ino_waddr;
    logic [WW-1:0]  ino_wdata;

    logic [31:0]    baddr;
    logic [BWA-1:0] bword;
    logic [WW-1:0]  bbit;
    logic [WW-1:0]  blk_rdata;
    logic           blk_we;
    logic [BWA-1:0] blk_waddr;
    logic [WW-1:0]  blk_wdata;

    assign span       = (32'(inode_limit) > 32'(INODE_COUNT)) ? LW'(INODE_COUNT) : inode_limit;
    assign span_m1    = span - LW'(1);
    assign last_word  = span_m1[LW-1:BWD];
    assign full_words = span[LW-1:BWD];
    assign tail_mask  = (WW'(1) << span[BWD-1:0]) - WW'(1);
    assign valid_mask = (32'(chk_reg) < 32'(full_words)) ? '1 : tail_mask;
    assign free_bits  = ~ino_rdata & valid_mask;
    assign any_free   = |free_bits;
    assign scan_last  = (32'(scan_reg) == 32'(last_word));
    assign chk_last   = (32'(chk_reg) == 32'(last_word));

    always_comb
    begin
        pos = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = BWD'(i);
            end
        end
    end

    assign clr_in_ino = (32'(clr_reg) < 32'(IW));
    assign clr_in_blk = (32'(clr_reg) < 32'(BW));

    assign baddr = (cmd_reg == bia_pkg::CMD_ALLOC) ? 32'(base_reg) : 32'(blk_reg);
    assign bword = BWA'(baddr >> BWD);
    assign bbit  = WW'(1) << baddr[BWD-1:0];

    assign ino_we    = (cmd.clr_step && clr_in_ino) || cmd.ino_write;
    assign ino_waddr = cmd.clr_step ? IWA'(clr_reg) : widx_reg;
    assign ino_wdata = cmd.clr_step ? '0 : word_reg;

    assign blk_we    = (cmd.clr_step && clr_in_blk) || cmd.blk_write;
    assign blk_waddr = cmd.clr_step ? BWA'(clr_reg) : bword;
    assign blk_wdata = cmd.clr_step ? '0 :
                       (cmd_reg == bia_pkg::CMD_FREE) ? (blk_rdata & ~bbit) : (blk_rdata | bbit);

    bia_ram #(
        .WIDTH (WW),
        .DEPTH (IW)
    ) u_ino_map (
        .clk   (clk),
        .we    (ino_we),
        .waddr (ino_waddr),
        .wdata (ino_wdata),
        .raddr (scan_reg),
        .rdata (ino_rdata)
    );

    bia_ram #(
        .WIDTH (WW),
        .DEPTH (BW)
    ) u_blk_map (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (bword),
        .rdata (blk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            scan_reg   <= '0;
            issued_reg <= 1'b0;
            rdv_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CLW'(1);
            end
            if (cmd.scan_start)
            begin
                scan_reg   <= '0;
                issued_reg <= 1'b0;
                rdv_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rdv_reg <= !issued_reg;
                if (!issued_reg)
                begin
                    if (scan_last)
                    begin
                        issued_reg <= 1'b1;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IWA'(1);
                    end
                end
            end
            else
            begin
                rdv_reg <= 1'b0;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= command;
            dir_reg <= is_directory;
            blk_reg <= block_index;
        end
        if (cmd.scan_step && !issued_reg)
        begin
            chk_reg <= scan_reg;
        end
        if (stat.hit)
        begin
            idx_reg  <= {chk_reg, pos};
            widx_reg <= chk_reg;
            word_reg <= ino_rdata | (WW'(1) << pos);
        end
        if (cmd.mul)
        begin
            base_reg <= PROD_W'(idx_reg) * PROD_W'(blocks_per_file);
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            inode_reg  <= (cmd.fin_status == bia_pkg::ST_OK && cmd_reg == bia_pkg::CMD_ALLOC)
                          ? IOW'(idx_reg) : '0;
        end
    end

    always_comb
    begin
        stat           = '0;
        stat.clr_done  = (32'(clr_reg) == 32'(CLR_N - 1));
        stat.span_zero = (span == '0);
        stat.hit       = cmd.scan_step && rdv_reg && any_free;
        stat.miss      = cmd.scan_step && rdv_reg && !any_free && chk_last;
        stat.base_oob  = (32'(base_reg) >= 32'(BLOCK_COUNT));
        stat.blk_oob   = (32'(blk_reg) >= 32'(BLOCK_COUNT));
        stat.cmd       = cmd_reg;
        stat.is_dir    = dir_reg;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign inode_number = inode_reg;

endmodule

`default_nettype wire
